@@ rtl/max_tracking_stack_macros.svh @@
// ---------------------------------------------------------------------------
// max_tracking_stack assertion macros
// Shorthand for clocked, reset-qualified properties used by the checker.
// ---------------------------------------------------------------------------
`ifndef MAX_TRACKING_STACK_MACROS_SVH
`define MAX_TRACKING_STACK_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MTS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mts_pkg.sv @@
// ---------------------------------------------------------------------------
// mts_pkg
// Shared types and defaults for the max-tracking stack.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One-cycle command to a cached-top stack
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mts_ram.sv @@
// ---------------------------------------------------------------------------
// mts_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data when not enabled
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mts_stack.sv @@
// ---------------------------------------------------------------------------
// mts_stack
// LIFO with the top entry and the entry below it always available.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mts_stack #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mts_pkg::stk_ctl_t     ctl,
  input  wire logic [DATA_WIDTH-1:0] wr_data,
  output logic      [DATA_WIDTH-1:0] top,
  output logic      [DATA_WIDTH-1:0] below,
  output logic      [CNT_W-1:0]      count
);
  import mts_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Entries under the top live in the RAM at their own index; the top is
  // held in a register.
  logic [DATA_WIDTH-1:0] top_r;
  logic [DATA_WIDTH-1:0] byp_r;
  logic                  use_byp_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic                  ram_we;
  logic                  ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [AW-1:0]         ram_raddr;
  logic [CNT_W-1:0]      waddr_full;
  logic [CNT_W-1:0]      raddr_full;

  assign waddr_full = cnt_r - CNT_W'(1);
  assign raddr_full = cnt_r - CNT_W'(3);
  assign ram_waddr  = waddr_full[AW-1:0];
  assign ram_raddr  = raddr_full[AW-1:0];
  // spill the old top under the new one
  assign ram_we     = ctl.push && (cnt_r != '0);
  // prefetch the entry that becomes "below" after this pop
  assign ram_re     = ctl.pop && (cnt_r >= CNT_W'(3));

  mts_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign below = use_byp_r ? byp_r : ram_rdata;
  assign top   = top_r;
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      use_byp_r <= 1'b0;
    end else if (ctl.push) begin
      cnt_r     <= cnt_r + CNT_W'(1);
      use_byp_r <= 1'b1;
    end else if (ctl.pop) begin
      cnt_r     <= cnt_r - CNT_W'(1);
      use_byp_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      top_r <= wr_data;
      byp_r <= top_r;
    end else if (ctl.pop) begin
      top_r <= below;
    end
  end

endmodule

`default_nettype wire

@@ rtl/max_tracking_stack.sv @@
// ---------------------------------------------------------------------------
// max_tracking_stack
// LIFO of signed values that reports its running maximum on every transfer.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transfer per operation. in_tuser[0] selects push
//   (0) or pop (1); in_tdata[31:0] carries the value to push.
//   Result channel out_*: exactly one transfer per input transfer, in order.
//   out_tuser carries the status (done, push rejected full, pop rejected
//   empty); out_tdata carries popped value, maximum, top, depth and an empty
//   flag, each as left after the operation.
// Timing and throughput:
//   A result is registered and out in the cycle after its input transfer. One
//   operation is taken every cycle unless out_tready stalls: both stacks keep
//   their top and the entry below it in registers, so a pop never waits for a
//   RAM read; the next entry down is read during the pop, landing when needed.
// Reset:
//   rst_n clears both counts and the output valid; the stack is empty. RAM
//   contents are never read before being written, so no clearing pass.
// Back-pressure:
//   The result register holds while out_tready is low; in_tready stays high
//   as long as that register is empty or being drained in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_tracking_stack #(
  parameter int DEPTH        = mts_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH   = mts_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W       = $clog2(DEPTH + 1),
  localparam int OUT_BITS    = 3 * mts_pkg::VALUE_W + CNT_W + 1,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [mts_pkg::VALUE_W-1:0]     in_tdata,   // [31:0] value
  input  wire logic [0:0]                      in_tuser,   // [0] op: 0 push, 1 pop
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [31:0] popped_value, [63:32] current_max, [95:64] top_value,
  // then depth_after (CNT_W bits), is_empty, zero fill
  output logic [OUT_TDATA_W-1:0]               out_tdata,
  output logic [mts_pkg::STATUS_W-1:0]         out_tuser   // [1:0] status
);
  import mts_pkg::*;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  // Input decode
  logic                         acc;
  logic                         is_pop;
  logic signed [DATA_WIDTH-1:0] in_val;

  // Stack views
  logic [DATA_WIDTH-1:0] vs_top, vs_below, ms_top, ms_below;
  logic [CNT_W-1:0]      vs_cnt, ms_cnt;
  stk_ctl_t              vs_ctl, ms_ctl;

  // Step outcome
  logic                  push_ok, pop_ok, max_push, max_pop;
  status_t               status;
  logic [CNT_W-1:0]      vs_cnt_nxt, ms_cnt_nxt;
  logic [DATA_WIDTH-1:0] top_nxt, max_nxt;
  logic [DATA_WIDTH-1:0] popped, top_out, max_out;

  // Result register
  logic                       out_valid_r;
  status_t                    status_r;
  logic [VALUE_W-1:0]         popped_r, max_r, top_r;
  logic [CNT_W-1:0]           depth_r;
  logic                       empty_r;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign is_pop    = in_tuser[0];
  // sign-extend or truncate the 32-bit value into the stored width
  assign in_val    = DATA_WIDTH'($signed(in_tdata));

  assign push_ok  = !is_pop && (vs_cnt != FULL);
  assign pop_ok   = is_pop && (vs_cnt != '0);
  // equal values go onto the max stack too, so duplicates pop correctly
  assign max_push = push_ok && ((ms_cnt == '0) || (in_val >= $signed(ms_top)));
  assign max_pop  = pop_ok && (ms_cnt != '0) && (ms_top == vs_top);

  always_comb begin
    if (!is_pop && !push_ok) begin
      status = ST_FULL;
    end else if (is_pop && !pop_ok) begin
      status = ST_EMPTY;
    end else begin
      status = ST_DONE;
    end
  end

  always_comb begin
    vs_cnt_nxt = vs_cnt;
    top_nxt    = vs_top;
    if (push_ok) begin
      vs_cnt_nxt = vs_cnt + CNT_W'(1);
      top_nxt    = in_val;
    end else if (pop_ok) begin
      vs_cnt_nxt = vs_cnt - CNT_W'(1);
      top_nxt    = vs_below;
    end
  end

  always_comb begin
    ms_cnt_nxt = ms_cnt;
    max_nxt    = ms_top;
    if (max_push) begin
      ms_cnt_nxt = ms_cnt + CNT_W'(1);
      max_nxt    = in_val;
    end else if (max_pop) begin
      ms_cnt_nxt = ms_cnt - CNT_W'(1);
      max_nxt    = ms_below;
    end
  end

  assign popped  = pop_ok ? vs_top : '0;
  assign top_out = (vs_cnt_nxt != '0) ? top_nxt : '0;
  assign max_out = (ms_cnt_nxt != '0) ? max_nxt : '0;

  // Commit only on an input transfer
  assign vs_ctl = '{push: acc && push_ok, pop: acc && pop_ok};
  assign ms_ctl = '{push: acc && max_push, pop: acc && max_pop};

  mts_stack #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_vals (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (vs_ctl),
    .wr_data (in_val),
    .top     (vs_top),
    .below   (vs_below),
    .count   (vs_cnt)
  );

  mts_stack #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_maxs (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ms_ctl),
    .wr_data (in_val),
    .top     (ms_top),
    .below   (ms_below),
    .count   (ms_cnt)
  );

  // Result valid: set on input transfer, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: load on input transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status;
      popped_r <= VALUE_W'($signed(popped));
      max_r    <= VALUE_W'($signed(max_out));
      top_r    <= VALUE_W'($signed(top_out));
      depth_r  <= vs_cnt_nxt;
      empty_r  <= (vs_cnt_nxt == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_TDATA_W'({empty_r, depth_r, top_r, max_r, popped_r});

endmodule

`default_nettype wire

@@ rtl/mts_checker.sv @@
// ---------------------------------------------------------------------------
// mts_checker
// Port-level checks on the max-tracking stack results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "max_tracking_stack_macros.svh"

module mts_checker #(
  parameter int DEPTH        = mts_pkg::DEPTH_DEF,
  localparam int CNT_W       = $clog2(DEPTH + 1),
  localparam int OUT_BITS    = 3 * mts_pkg::VALUE_W + CNT_W + 1,
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [OUT_TDATA_W-1:0]      out_tdata,
  input wire logic [mts_pkg::STATUS_W-1:0] out_tuser
);
  import mts_pkg::*;

  localparam int DEP_LO = 3 * VALUE_W;
  localparam int EMP_BIT = DEP_LO + CNT_W;

  logic [VALUE_W-1:0] popped_w, max_w, top_w;
  logic [CNT_W-1:0]   depth_w;
  logic               empty_w;

  assign popped_w = out_tdata[VALUE_W-1:0];
  assign max_w    = out_tdata[2*VALUE_W-1:VALUE_W];
  assign top_w    = out_tdata[DEP_LO-1:2*VALUE_W];
  assign depth_w  = out_tdata[EMP_BIT-1:DEP_LO];
  assign empty_w  = out_tdata[EMP_BIT];

  `MTS_ASSERT_IMPLY(a_depth_range, out_tvalid, depth_w <= CNT_W'(DEPTH), "depth beyond capacity")
  `MTS_ASSERT_IMPLY(a_empty_flag, out_tvalid, empty_w == (depth_w == '0), "empty flag disagrees with depth")
  `MTS_ASSERT_IMPLY(a_reject_no_pop, out_tvalid && (out_tuser != ST_DONE), popped_w == '0, "rejected step returned a value")
  `MTS_ASSERT_IMPLY(a_empty_zero, out_tvalid && empty_w, (max_w == '0) && (top_w == '0), "empty stack reports nonzero top or max")
  `MTS_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

endmodule

bind max_tracking_stack mts_checker #(
  .DEPTH (DEPTH)
) u_mts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
